### hw/rtl/iir_bandpass_order4_defines.svh
// assertion macros for the order-4 band-pass filter
// used by the top level only; expects clk and rst_n in scope
`ifndef IIR_BANDPASS_ORDER4_DEFINES_SVH
`define IIR_BANDPASS_ORDER4_DEFINES_SVH

// same-cycle implication, checked out of reset
`define IBP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define IBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ibp_pkg.sv
// shared types and constants of the order-4 band-pass filter
// no dependencies
package ibp_pkg;

  typedef enum logic {
    MODE_BREATH = 1'b0,
    MODE_HEART  = 1'b1
  } mode_t;

  // register map
  localparam int PADDR_W          = 3;
  localparam int REG_FILTER_MODE  = 0;

  // pipeline control from the top level to the datapath
  typedef struct packed {
    logic load_in;
    logic advance;
  } ibp_ctrl_t;

  // coefficients scaled by 2^30; b1 and b3 are zero and left out
  localparam longint COEF_B30 [2][3] = '{
    '{64'sd654826, -64'sd1309653, 64'sd654826},
    '{64'sd18717260, -64'sd37434520, 64'sd18717260}
  };
  localparam longint COEF_A30 [2][4] = '{
    '{-64'sd4215624704, 64'sd6210195967, -64'sd4068374271, 64'sd1000063488},
    '{-64'sd3780671488, 64'sd5068047360, -64'sd3071655424, 64'sd711953728}
  };

  // reduce a 2^30 coefficient to frac bits, rounding half up; unchanged when frac >= 30
  function automatic longint coef_scale(longint c30, int frac);
    int s;
    s = 30 - frac;
    if (s <= 0) begin
      return c30;
    end
    return (c30 + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

endpackage

### hw/rtl/iir_bandpass_order4.sv
// order-4 direct-form-i band-pass filter, top level
// usage: one signed sample word in, one q16.16 word out, valid/stall on both sides.
// a mode register at byte address 0 (bit 0) picks the breathing band (0) or the
// heart band (1); write it only while the filter is idle.
// in_frame_start clears the four past inputs and outputs before its sample.
// an accepted word waits in the input register and moves into the result register
// once that is empty or not stalled; out_valid is set with the result register.
// throughput: one word per cycle while out_stall is low; the feedback loop (seven multiplies,
// one sum, rounding and clipping) is combinational between input and result register.
// when out_stall is high the result holds and one further word may wait in the
// input register; in_stall rises only while both are occupied and the output stalls.
// reset (rst_n low, synchronous) empties both registers, clears the history and
// selects the breathing band.
// depends on ibp_pkg, ibp_cfg_regs, ibp_coef_sel, ibp_datapath and the defines header
`include "iir_bandpass_order4_defines.svh"

module iir_bandpass_order4 import ibp_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_frame_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_filtered,
  output logic                           out_saturated,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [PADDR_W-1:0]             paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int COEF_W = COEF_FRAC_BITS + 4;

  mode_t                    filter_mode;
  logic signed [COEF_W-1:0] coef_b [3];
  logic signed [COEF_W-1:0] coef_a [4];
  ibp_ctrl_t                ctrl;

  logic s1_valid_r;
  logic s1_valid_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  ibp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .filter_mode (filter_mode)
  );

  ibp_coef_sel #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .COEF_W         (COEF_W)
  ) u_coef (
    .filter_mode (filter_mode),
    .coef_b      (coef_b),
    .coef_a      (coef_a)
  );

  ibp_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .COEF_W         (COEF_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .in_sample      (in_sample),
    .in_frame_start (in_frame_start),
    .coef_b         (coef_b),
    .coef_a         (coef_a),
    .out_filtered   (out_filtered),
    .out_saturated  (out_saturated)
  );

  always_comb begin
    ctrl.advance = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall     = s1_valid_r && !ctrl.advance;
    ctrl.load_in = in_valid && !in_stall;
  end

  always_comb begin
    s1_valid_nxt  = ctrl.load_in || (s1_valid_r && !ctrl.advance);
    out_valid_nxt = ctrl.advance || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `IBP_ASSERT_SAME(a_sat_at_rail, out_valid && out_saturated, (out_filtered == 32'sh7fff_ffff) || (out_filtered == 32'sh8000_0000), "saturated word not at a rail")
  `IBP_ASSERT_NEXT(a_advance_shows, ctrl.advance, out_valid, "advanced word not presented")
  `IBP_ASSERT_NEXT(a_waiting_kept, s1_valid_r && out_valid && out_stall, s1_valid_r, "waiting word dropped")

endmodule

### hw/rtl/ibp_cfg_regs.sv
// configuration register block (mode select) on an apb-style port
// depends on ibp_pkg
module ibp_cfg_regs import ibp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mode_t              filter_mode
);

  mode_t mode_r;
  mode_t mode_nxt;
  logic  hit;

  assign hit    = (paddr[PADDR_W-1:2] == 1'(REG_FILTER_MODE));
  assign pready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (psel && penable && pwrite && hit) begin
      mode_nxt = mode_t'(pwdata[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BREATH;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign prdata      = hit ? {31'd0, mode_r} : 32'd0;
  assign filter_mode = mode_r;

endmodule

### hw/rtl/ibp_coef_sel.sv
// coefficient tables for both bands, scaled to the configured fraction width
// depends on ibp_pkg
module ibp_coef_sel import ibp_pkg::*; #(
  parameter int COEF_FRAC_BITS = 28,
  parameter int COEF_W         = 32
) (
  input  mode_t                    filter_mode,
  output logic signed [COEF_W-1:0] coef_b [3],
  output logic signed [COEF_W-1:0] coef_a [4]
);

  always_comb begin
    unique case (filter_mode)
      MODE_BREATH: begin
        for (int k = 0; k < 3; k++) begin
          coef_b[k] = COEF_W'(coef_scale(COEF_B30[0][k], COEF_FRAC_BITS));
        end
        for (int k = 0; k < 4; k++) begin
          coef_a[k] = COEF_W'(coef_scale(COEF_A30[0][k], COEF_FRAC_BITS));
        end
      end
      MODE_HEART: begin
        for (int k = 0; k < 3; k++) begin
          coef_b[k] = COEF_W'(coef_scale(COEF_B30[1][k], COEF_FRAC_BITS));
        end
        for (int k = 0; k < 4; k++) begin
          coef_a[k] = COEF_W'(coef_scale(COEF_A30[1][k], COEF_FRAC_BITS));
        end
      end
    endcase
  end

endmodule

### hw/rtl/ibp_datapath.sv
// input register, history, multiply-accumulate, rounding, saturation, result register
// depends on ibp_pkg
module ibp_datapath import ibp_pkg::*; #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 28,
  parameter int COEF_W         = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ibp_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                          in_frame_start,
  input  logic signed [COEF_W-1:0]      coef_b [3],
  input  logic signed [COEF_W-1:0]      coef_a [4],
  output logic signed [31:0]            out_filtered,
  output logic                          out_saturated
);

  localparam int PB_W  = COEF_W + SAMPLE_WIDTH;
  localparam int PA_W  = COEF_W + 32;
  localparam int ACC_W = COEF_W + 35;
  localparam int YW_W  = ACC_W - COEF_FRAC_BITS;

  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic                           fs_r;
  logic signed [SAMPLE_WIDTH-1:0] hist_x_r [4];
  logic signed [31:0]             hist_y_r [4];
  logic signed [31:0]             filtered_r;
  logic                           sat_r;

  logic signed [SAMPLE_WIDTH-1:0] hx [4];
  logic signed [31:0]             hy [4];
  logic signed [PB_W-1:0]         prod_b [3];
  logic signed [PA_W-1:0]         prod_a [4];
  logic signed [ACC_W-1:0]        ff_sum;
  logic signed [ACC_W-1:0]        fb_sum;
  logic signed [ACC_W-1:0]        acc;
  logic signed [YW_W-1:0]         y_wide;
  logic signed [31:0]             y_nxt;
  logic                           sat_nxt;

  // frame start sees an all-zero history
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hx[k] = fs_r ? '0 : hist_x_r[k];
      hy[k] = fs_r ? '0 : hist_y_r[k];
    end
  end

  always_comb begin
    prod_b[0] = coef_b[0] * x_r;
    prod_b[1] = coef_b[1] * hx[1];
    prod_b[2] = coef_b[2] * hx[3];
    for (int k = 0; k < 4; k++) begin
      prod_a[k] = coef_a[k] * hy[k];
    end
  end

  // sum at coef_frac_bits + 16 fraction bits, then round half up to q16.16
  always_comb begin
    ff_sum = ACC_W'(prod_b[0]) + ACC_W'(prod_b[1]) + ACC_W'(prod_b[2]);
    fb_sum = ACC_W'(prod_a[0]) + ACC_W'(prod_a[1]) + ACC_W'(prod_a[2])
           + ACC_W'(prod_a[3]);
    acc    = (ff_sum <<< 16) - fb_sum + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
    y_wide = YW_W'(acc >>> COEF_FRAC_BITS);
  end

  always_comb begin
    if (!y_wide[YW_W-1] && (|y_wide[YW_W-2:31])) begin
      y_nxt   = 32'sh7fff_ffff;
      sat_nxt = 1'b1;
    end else if (y_wide[YW_W-1] && !(&y_wide[YW_W-2:31])) begin
      y_nxt   = 32'sh8000_0000;
      sat_nxt = 1'b1;
    end else begin
      y_nxt   = y_wide[31:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      x_r  <= in_sample;
      fs_r <= in_frame_start;
    end
    if (ctrl.advance) begin
      filtered_r <= y_nxt;
      sat_r      <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) begin
        hist_x_r[k] <= '0;
        hist_y_r[k] <= '0;
      end
    end else if (ctrl.advance) begin
      hist_x_r[0] <= x_r;
      hist_y_r[0] <= y_nxt;
      for (int k = 1; k < 4; k++) begin
        hist_x_r[k] <= hx[k-1];
        hist_y_r[k] <= hy[k-1];
      end
    end
  end

  assign out_filtered  = filtered_r;
  assign out_saturated = sat_r;

endmodule

### tb/sv/testbench.sv
// self-checking testbench for the order-4 band-pass filter iir_bandpass_order4
// predicts each output word in the testbench and checks it, with bursty input and random stall
// depends on ibp_pkg and the filter rtl
`timescale 1ns / 1ps

module testbench;
  import ibp_pkg::*;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_FRAC   = 28;
  localparam int COEF_SHIFT  = 30 - COEF_FRAC;
  localparam int IDLE_LIMIT  = 1000;
  localparam int PHASE_WORDS = 85;
  localparam longint Y_MAX   = 64'sd2147483647;
  localparam longint Y_MIN   = -64'sd2147483648;

  // taps scaled by 2^30, breathing band first
  localparam longint TAP_B30 [2][5] = '{
    '{64'sd654826, 64'sd0, -64'sd1309653, 64'sd0, 64'sd654826},
    '{64'sd18717260, 64'sd0, -64'sd37434520, 64'sd0, 64'sd18717260}
  };
  localparam longint TAP_A30 [2][4] = '{
    '{-64'sd4215624704, 64'sd6210195967, -64'sd4068374271, 64'sd1000063488},
    '{-64'sd3780671488, 64'sd5068047360, -64'sd3071655424, 64'sd711953728}
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_start;
  } sample_word_t;

  typedef struct packed {
    logic signed [31:0] filtered;
    logic               saturated;
  } filter_word_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       in_frame_start = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [31:0]         out_filtered;
  logic                       out_saturated;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [PADDR_W-1:0]         paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  sample_word_t sample_queue[$];
  filter_word_t filtered_queue[$];

  mode_t  band_sel = MODE_BREATH;
  longint x_hist [4] = '{0, 0, 0, 0};
  longint y_hist [4] = '{0, 0, 0, 0};

  bit           in_taken = 1'b0;
  int           gap_left = 0;
  int           burst_left = 1;
  int           stall_left = 0;
  stall_style_t stall_style = STALL_NONE;
  int           idle_cycles = 0;
  int           err_count = 0;

  iir_bandpass_order4 #(
    .SAMPLE_WIDTH  (SAMPLE_W),
    .COEF_FRAC_BITS(COEF_FRAC)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_frame_start(in_frame_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_filtered  (out_filtered),
    .out_saturated (out_saturated),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic filter_word_t filter_sample(logic signed [SAMPLE_W-1:0] s, logic fs);
    longint       x;
    longint       acc_hi;
    longint       acc_lo;
    longint       c;
    longint       c_hi;
    longint       total;
    longint       y;
    int           m;
    int           k;
    filter_word_t r;
    x = longint'(s);
    m = int'(band_sel);
    if (fs) begin
      for (k = 0; k < 4; k++) begin
        x_hist[k] = 0;
        y_hist[k] = 0;
      end
    end
    acc_hi = 0;
    for (k = 0; k < 5; k++) begin
      c = (TAP_B30[m][k] + (64'sd1 <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT;
      acc_hi += c * ((k == 0) ? x : x_hist[k-1]);
    end
    // feedback split into upper part and low 16 bits to stay within 64 bits
    acc_lo = 0;
    for (k = 0; k < 4; k++) begin
      c = (TAP_A30[m][k] + (64'sd1 <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT;
      c_hi = c >>> 16;
      acc_hi -= c_hi * y_hist[k];
      acc_lo -= (c - (c_hi <<< 16)) * y_hist[k];
    end
    total = acc_hi + (acc_lo >>> 16);
    y = (total + (64'sd1 <<< (COEF_FRAC - 17))) >>> (COEF_FRAC - 16);
    r.saturated = 1'b0;
    if (y > Y_MAX) begin
      y = Y_MAX;
      r.saturated = 1'b1;
    end else if (y < Y_MIN) begin
      y = Y_MIN;
      r.saturated = 1'b1;
    end
    for (k = 3; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = y;
    r.filtered = 32'(y);
    return r;
  endfunction

  // input driver: bursts of words with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        sample_word_t w;
        w = sample_queue.pop_front();
        in_sample      <= w.sample;
        in_frame_start <= w.frame_start;
        in_valid       <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall in stretches of differing style
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left  = $urandom_range(16, 128);
    end
    stall_left--;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken    = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (filtered_queue.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected word: filtered %0d saturated %0b", out_filtered, out_saturated);
          end
        end else begin
          filter_word_t want;
          want = filtered_queue.pop_front();
          if (want.filtered !== out_filtered || want.saturated !== out_saturated) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch: filtered exp %0d got %0d, saturated exp %0b got %0b",
                       want.filtered, out_filtered, want.saturated, out_saturated);
            end
          end
        end
      end
      if (in_taken) begin
        filtered_queue.push_back(filter_sample(in_sample, in_frame_start));
      end
      if (in_taken || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(input int idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_FILTER_MODE) begin
      band_sel = mode_t'(value[0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_word(input int v, input bit fs);
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    sample_queue.push_back('{sample: SAMPLE_W'(v), frame_start: fs});
  endtask

  task automatic wait_idle();
    while (sample_queue.size() != 0 || in_valid || filtered_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int    p;
    int    i;
    int    count;
    int    len;
    int    half;
    int    amp;
    int    pos;
    int    v;
    bit    square;
    mode_t phase_mode;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // breathing band: extremes, frame start, impulse tail
    write_reg(REG_FILTER_MODE, 32'h0);
    queue_word(32767, 1'b1);
    queue_word(32767, 1'b0);
    queue_word(32767, 1'b0);
    queue_word(-32768, 1'b0);
    queue_word(-32768, 1'b0);
    queue_word(0, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(1, 1'b0);
    queue_word(21845, 1'b0);
    queue_word(-21846, 1'b0);
    queue_word(-32768, 1'b1);
    queue_word(0, 1'b0);
    queue_word(0, 1'b0);
    queue_word(0, 1'b0);
    wait_idle();

    // heart band with upper data bits set; history kept over the switch
    write_reg(REG_FILTER_MODE, 32'hffff_fffe | 32'(MODE_HEART));
    write_reg(REG_FILTER_MODE + 1, 32'h0);
    queue_word(32767, 1'b0);
    queue_word(-32768, 1'b1);
    queue_word(32767, 1'b0);
    queue_word(0, 1'b0);
    queue_word(-1, 1'b0);
    queue_word(0, 1'b1);
    queue_word(12345, 1'b0);
    wait_idle();

    for (p = 0; p < 6; p++) begin
      phase_mode = (p % 2 == 0) ? MODE_BREATH : MODE_HEART;
      write_reg(REG_FILTER_MODE, ($urandom() & 32'hffff_fffe) | 32'(phase_mode));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(REG_FILTER_MODE + 1, $urandom());
      end
      count = 0;
      while (count < PHASE_WORDS) begin
        if ($urandom_range(0, 3) != 0) begin
          // framed tone near the pass band, often at full scale
          amp    = ($urandom_range(0, 2) == 0) ? 32767 : $urandom_range(0, 32767);
          half   = (phase_mode == MODE_HEART) ? $urandom_range(4, 20) : $urandom_range(20, 60);
          len    = $urandom_range(2 * half, 6 * half);
          square = $urandom_range(0, 1);
          if (len > 150) begin
            len = 150;
          end
          for (i = 0; i < len; i++) begin
            pos = i % (2 * half);
            if (square) begin
              v = (pos < half) ? amp : -amp - 1;
            end else if (pos < half) begin
              v = -amp + 2 * amp * pos / half;
            end else begin
              v = amp - 2 * amp * (pos - half) / half;
            end
            v += int'($urandom_range(0, 64)) - 32;
            queue_word(v, i == 0);
          end
        end else begin
          len = $urandom_range(4, 40);
          for (i = 0; i < len; i++) begin
            queue_word(int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, 15) == 0);
          end
        end
        count += len;
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ibp_pkg.sv
hw/rtl/ibp_cfg_regs.sv
hw/rtl/ibp_coef_sel.sv
hw/rtl/ibp_datapath.sv
hw/rtl/iir_bandpass_order4.sv
tb/sv/testbench.sv
